// ===== rtl/core/pdm_cic_halfband_decimator_defines.svh =====
// assertion macros for the pdm decimator
`ifndef PDM_CIC_HALFBAND_DECIMATOR_DEFINES_SVH
`define PDM_CIC_HALFBAND_DECIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PDMCHD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PDMCHD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PDMCHD_ASSERT(lbl, prop, msg)
`define PDMCHD_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/core/pdmchd_pkg.sv =====
// shared constants and tables for the pdm decimator
`timescale 1ns / 1ps
`default_nettype none
package pdmchd_pkg;
  localparam int HIST_DEPTH = 64;
  localparam int HIST_AW    = 6;
  localparam int HB_TAPS    = 47;
  localparam int SINC_LEN   = 125;
  localparam int CIC_WW     = 21;
  localparam int HIST_W     = 24;
  localparam int GAIN_W     = 24;
  localparam int COEF_W     = 17;
  localparam int MUL_AW     = 26;
  localparam int PROD_W     = MUL_AW + GAIN_W;
  localparam int FACC_W     = 41;

  typedef logic [CIC_WW-1:0] cic_tab_t [128];

  // sinc^4 weights, worked out at elaboration
  function automatic cic_tab_t cic_build();
    cic_tab_t tab;
    int bin [5];
    int s;
    int t;
    bin[0] = 1; bin[1] = -4; bin[2] = 6; bin[3] = -4; bin[4] = 1;
    for (int i = 0; i < 128; i++) begin
      s = 0;
      for (int k = 0; k < 5; k++) begin
        t = i - 32 * k;
        if (t >= 0) s = s + bin[k] * ((t + 3) * (t + 2) * (t + 1) / 6);
      end
      tab[i] = (i < SINC_LEN) ? s[CIC_WW-1:0] : '0;
    end
    return tab;
  endfunction

  localparam cic_tab_t CIC_TAB = cic_build();

  // half-band coefficients, q15
  localparam logic signed [COEF_W-1:0] HB_TAB [HB_TAPS] = '{
    17'sd0, 17'sd0, 17'sd3, 17'sd0, -17'sd16, 17'sd0, 17'sd45, 17'sd0,
    -17'sd100, 17'sd0, 17'sd196, 17'sd0, -17'sd355, 17'sd0, 17'sd609, 17'sd0,
    -17'sd1016, 17'sd0, 17'sd1719, 17'sd0, -17'sd3245, 17'sd0, 17'sd10351,
    17'sd16384, 17'sd10351, 17'sd0, -17'sd3245, 17'sd0, 17'sd1719, 17'sd0,
    -17'sd1016, 17'sd0, 17'sd609, 17'sd0, -17'sd355, 17'sd0, 17'sd196, 17'sd0,
    -17'sd100, 17'sd0, 17'sd45, 17'sd0, -17'sd16, 17'sd0, 17'sd3, 17'sd0, 17'sd0
  };
endpackage
`default_nettype wire

// ===== rtl/core/pdmchd_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pdmchd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/pdm_cic_halfband_decimator.sv =====
// pdm to pcm decimator: sinc^4, dc blocker, half-band fir and gain
//
//  channel  | signals                      | direction
//  input    | in_valid, in_ready, pdm_word | in
//  output   | out_valid, out_ready, sample | out
//  config   | cfg_we, cfg_data             | in
//
// a word that only fills the window is just stored
// a window word runs sinc^4 accumulation over 125 window bits, then a blocker step
// every second such word adds a fir pass over the 47 taps (one tap per cycle on the
// history ram read port and the shared multiplier) and the gain and saturation steps
// rst clears state, gain to unity and all history valid bits at once
// a result waits in the output register; only the saturation step stalls on it
`timescale 1ns / 1ps
`default_nettype none
`include "pdm_cic_halfband_decimator_defines.svh"
module pdm_cic_halfband_decimator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [31:0]                         pdm_word,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [15:0]                       sample,
  input  wire logic                                cfg_we,
  input  wire logic signed [pdmchd_pkg::GAIN_W-1:0] cfg_data
);
  import pdmchd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CIC, S_BLK, S_FIR, S_GAIN, S_SAT} state_t;

  state_t                     state;
  logic signed [GAIN_W-1:0]   gain;
  logic [31:0]                w0, w1, w2;
  logic [1:0]                 fill;
  logic [127:0]               win;
  logic [6:0]                 idx;
  logic [CIC_WW-1:0]          cic_acc;
  logic signed [16:0]         prev;
  logic [31:0]                bacc;
  logic [HIST_AW-1:0]         head;
  logic                       phase;
  logic [HIST_DEPTH-1:0]      hvalid;
  logic [5:0]                 tap;
  logic                       s1_v, s2_v, hv_q;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [FACC_W-1:0]   facc;

  logic signed [21:0]         cic_t;
  logic signed [16:0]         x;
  logic signed [17:0]         diff;
  logic [31:0]                bacc_next;
  logic [HIST_AW-1:0]         head_next;
  logic [HIST_AW-1:0]         raddr;
  logic [HIST_W-1:0]          rd_data;
  logic                       ram_we;
  logic signed [MUL_AW-1:0]   mul_a;
  logic signed [GAIN_W-1:0]   mul_b;
  logic signed [34:0]         gained;
  logic signed [15:0]         sat;
  logic                       sat_fire;

  assign in_ready = (state == S_IDLE);

  // sinc^4 result and dc blocker arithmetic
  assign cic_t     = $signed({1'b0, cic_acc} <<< 1) - 22'sd1048576;
  assign x         = cic_t[21:5];
  assign diff      = {x[16], x} - {prev[16], prev};
  assign bacc_next = {{6{diff[17]}}, diff, 8'd0} + bacc - {{8{bacc[31]}}, bacc[31:8]};
  assign head_next = head + 1'b1;
  assign raddr     = head - tap;
  assign ram_we    = (state == S_BLK);

  pdmchd_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_next),
    .wdata (bacc_next[31:8]),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // shared multiplier operands, gain product held while the result waits
  always_comb begin
    if (state inside {S_GAIN, S_SAT}) begin
      mul_a = facc[FACC_W-1:15];
      mul_b = gain;
    end else begin
      mul_a = MUL_AW'(coef_q);
      mul_b = hv_q ? $signed(rd_data) : '0;
    end
  end

  // gain shift and saturation
  assign gained = prod[PROD_W-1:15];
  always_comb begin
    if (gained > 35'sd32767) sat = 16'sh7fff;
    else if (gained < -35'sd32768) sat = 16'sh8000;
    else sat = gained[15:0];
  end

  // output register takes a new word when free or being emptied
  assign sat_fire = (state == S_SAT) && (!out_valid || out_ready);

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state     <= S_IDLE;
      gain      <= 24'sd32768;
      fill      <= '0;
      w0        <= '0;
      w1        <= '0;
      w2        <= '0;
      prev      <= '0;
      bacc      <= '0;
      head      <= '0;
      phase     <= 1'b0;
      hvalid    <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) gain <= cfg_data;
      if (sat_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (fill != 2'd3) begin
              case (fill)
                2'd0:    w0 <= pdm_word;
                2'd1:    w1 <= pdm_word;
                default: w2 <= pdm_word;
              endcase
              fill <= fill + 1'b1;
            end else begin
              win     <= {pdm_word, w2, w1, w0};
              w0      <= w1;
              w1      <= w2;
              w2      <= pdm_word;
              idx     <= '0;
              cic_acc <= '0;
              state   <= S_CIC;
            end
          end
        end
        S_CIC: begin
          if (win[0]) cic_acc <= cic_acc + CIC_TAB[idx];
          win <= win >> 1;
          idx <= idx + 1'b1;
          if (idx == 7'(SINC_LEN - 1)) state <= S_BLK;
        end
        S_BLK: begin
          prev             <= x;
          bacc             <= bacc_next;
          head             <= head_next;
          hvalid[head_next] <= 1'b1;
          phase            <= ~phase;
          tap              <= '0;
          facc             <= '0;
          s1_v             <= 1'b0;
          s2_v             <= 1'b0;
          state            <= phase ? S_FIR : S_IDLE;
        end
        S_FIR: begin
          if (tap != 6'(HB_TAPS)) begin
            coef_q <= HB_TAB[tap];
            hv_q   <= hvalid[raddr];
            s1_v   <= 1'b1;
            tap    <= tap + 1'b1;
          end else begin
            s1_v <= 1'b0;
          end
          s2_v <= s1_v;
          if (s2_v) facc <= facc + prod[FACC_W-1:0];
          if (tap == 6'(HB_TAPS) && !s1_v && !s2_v) state <= S_GAIN;
        end
        S_GAIN: begin
          state <= S_SAT;
        end
        S_SAT: begin
          if (sat_fire) begin
            sample <= sat;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `PDMCHD_ASSERT(a_busy_after_accept, (in_valid && in_ready && fill == 2'd3) |=> !in_ready, "window word did not start work")
  `PDMCHD_ASSERT(a_sat_holds, (state == S_SAT && out_valid && !out_ready) |=> (state == S_SAT && out_valid), "result dropped while output slot full")
  `PDMCHD_NEVER(a_tap_range, (state == S_FIR && tap > 6'(HB_TAPS)), "fir tap counter overran")
  `PDMCHD_NEVER(a_fir_needs_window, (state == S_FIR && fill != 2'd3), "fir started before window filled")
endmodule
`default_nettype wire

// ===== verif/pdm_cic_halfband_decimator_tb.sv =====
// self-checking testbench for the pdm to pcm decimator
`timescale 1ns / 1ps
module pdm_cic_halfband_decimator_tb;
  import pdmchd_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int N_RANDOM    = 1680;
  localparam int N_DIRECTED  = 16;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [31:0] pdm_word;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] sample;
  logic cfg_we;
  logic signed [GAIN_W-1:0] cfg_data;

  pdm_cic_halfband_decimator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pdm_word(pdm_word),
    .out_valid(out_valid), .out_ready(out_ready), .sample(sample),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0]        kept_words [3];
  int                 words_held;
  longint             last_cic;
  logic [31:0]        blocker_q8;
  longint             fir_hist [HIST_DEPTH];
  int                 hist_head;
  bit                 odd_phase;
  longint             gain_now;
  longint             sinc_weight [128];
  longint             hb_coef [HIST_DEPTH];

  logic signed [15:0] expected_samples [$];
  int                 mismatches;
  int                 idle_cycles;
  bit                 hold_receiver;
  bit                 cool_down;

  // directed stimulus: word, whether a fixed sample is known, that sample
  typedef struct {
    logic [31:0]        word;
    bit                 known;
    logic signed [15:0] value;
  } dir_row_t;
  dir_row_t dir_rows [N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // floor shift of a signed value
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  task automatic predictor_reset();
    for (int i = 0; i < 3; i++) kept_words[i] = '0;
    for (int i = 0; i < HIST_DEPTH; i++) fir_hist[i] = 0;
    words_held = 0;
    last_cic   = 0;
    blocker_q8 = '0;
    hist_head  = 0;
    odd_phase  = 1'b0;
    gain_now   = 32768;
  endtask

  // work out the sample, if any, that one word produces
  task automatic predict_word(input logic [31:0] w);
    logic [31:0] win [4];
    longint acc, x, diff, y, fa, filt, v;
    logic [31:0] nxt;
    int slot;
    if (words_held < 3) begin
      kept_words[words_held] = w;
      words_held++;
      return;
    end
    win[0] = kept_words[0]; win[1] = kept_words[1];
    win[2] = kept_words[2]; win[3] = w;
    acc = 0;
    for (int i = 0; i < 125; i++)
      if (win[i / 32][i % 32]) acc += sinc_weight[i];
    x = floor_shr(2 * acc - (longint'(1) << 20), 5);
    kept_words[0] = kept_words[1];
    kept_words[1] = kept_words[2];
    kept_words[2] = w;
    // leaky dc blocker, 32-bit wrapping accumulator
    diff = x - last_cic;
    nxt = 32'(diff << 8) + blocker_q8 - 32'(floor_shr(longint'($signed(blocker_q8)), 8));
    blocker_q8 = nxt;
    last_cic = x;
    y = floor_shr(longint'($signed(nxt)), 8);
    hist_head = (hist_head + 1) % HIST_DEPTH;
    fir_hist[hist_head] = y;
    odd_phase = ~odd_phase;
    if (odd_phase) return;
    fa = 0;
    for (int n = 0; n < HB_TAPS; n++) begin
      slot = (hist_head + HIST_DEPTH * 4 - n) % HIST_DEPTH;
      fa += hb_coef[n] * fir_hist[slot];
    end
    filt = longint'(int'(floor_shr(fa, 15)));
    v = floor_shr(filt * gain_now, 15);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    expected_samples.push_back(16'(v));
  endtask

  task automatic send_word(input logic [31:0] w);
    pdm_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(w);
  endtask

  task automatic sender_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 200) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n == 0) return;
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // pause the sender until everything expected has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_gain(input longint g);
    cfg_data <= GAIN_W'(g);
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    gain_now = g;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0000_0000;
      2: return 32'hAAAA_AAAA ^ {$urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF};
      default: return $urandom();
    endcase
  endfunction

  // receiver: random ready, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_receiver = 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0) || cool_down;
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("pdm_cic_halfband_decimator_tb: FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected sample %0d", sample);
        end else begin
          if (sample !== expected_samples[0]) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("sample mismatch: expected %0d got %0d",
                       expected_samples[0], sample);
          end
          void'(expected_samples.pop_front());
        end
      end
    end
  end

  initial begin
    longint s;
    int t;
    rst = 1'b1;
    in_valid = 1'b0;
    pdm_word = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    hold_receiver = 1'b0;
    cool_down = 1'b0;
    for (int i = 0; i < 128; i++) begin
      s = 0;
      for (int k = 0; k < 5; k++) begin
        t = i - 32 * k;
        if (t >= 0)
          s += (k == 0 ? 1 : k == 1 ? -4 : k == 2 ? 6 : k == 3 ? -4 : 1) *
               ((t + 3) * (t + 2) * (t + 1) / 6);
      end
      sinc_weight[i] = (i < 125) ? s : 0;
    end
    for (int i = 0; i < HIST_DEPTH; i++) hb_coef[i] = (i < HB_TAPS) ? HB_TAB[i] : 0;
    predictor_reset();

    // directed table: all-zero then all-one streams, then bit extremes
    for (int i = 0; i < N_DIRECTED; i++) begin
      dir_rows[i].known = 1'b0;
      dir_rows[i].value = '0;
      if (i < 6) dir_rows[i].word = 32'h0000_0000;
      else if (i < 12) dir_rows[i].word = 32'hFFFF_FFFF;
      else dir_rows[i].word = (i % 2) ? 32'h8000_0001 : 32'hE000_0000;
    end
    // the first sample out of all-zero words is pulled down from rest
    dir_rows[3].known = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].word);
      if (dir_rows[i].known && expected_samples.size() != 0)
        expected_samples[expected_samples.size() - 1] = dir_rows[i].value;
    end
    drain();

    // gain extremes with full-scale input, saturation both ways
    write_gain(-8388608);
    repeat (8) send_word(32'hFFFF_FFFF);
    drain();
    write_gain(8388607);
    repeat (8) send_word(32'h0000_0000);
    drain();
    write_gain(0);
    repeat (4) send_word($urandom());
    drain();
    write_gain(32768);

    // random part, several gain settings; one long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) hold_receiver = 1'b1;
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        send_word(random_word());
        sender_gap();
      end
      drain();
      write_gain(ph == 5 ? 32768 : $signed(24'($urandom())) >>> $urandom_range(0, 8));
    end

    cool_down = 1'b1;
    drain();
    if (mismatches == 0 && expected_samples.size() == 0)
      $display("pdm_cic_halfband_decimator_tb: PASS");
    else
      $display("pdm_cic_halfband_decimator_tb: FAIL");
    $finish;
  end
endmodule
